// ===== rtl/nnli_pkg.sv =====
package nnli_pkg;

  // Capacities and field widths
  localparam int MAX_BYTES  = 1048576;
  localparam int MAX_LINES  = 4096;
  localparam int BC_W       = 21;            // byte counts and offsets
  localparam int LF_W       = $clog2(MAX_LINES); // LF count and table address
  localparam int LN_W       = LF_W + 1;      // line numbers and line counts
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;

  // Item kinds carried in in_tuser
  localparam logic [1:0] OP_BYTE        = 2'd0;
  localparam logic [1:0] OP_FINISH      = 2'd1;
  localparam logic [1:0] OP_LINE_OF_POS = 2'd2;
  localparam logic [1:0] OP_LINE_BOUNDS = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_PHASE = 2'd2;
  localparam logic [1:0] STAT_OVFL  = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic pos_chk;    // test lo < hi, read table at mid
    logic pos_cmp;    // narrow the search window
    logic bnd_rd;     // read start of the queried line
    logic bnd_caps;   // capture start, read end if needed
    logic bnd_cape;   // capture end
    logic done_load;  // load the query result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic go_pos;      // accepted item starts a position search
    logic go_bnd;      // accepted item starts a bounds lookup
    logic lo_lt_hi;    // search window not yet empty
    logic ln_lt_total; // queried line is not the last one
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ===== rtl/nnli_ctrl.sv =====
module nnli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  nnli_pkg::sts_t sts,
  output nnli_pkg::cmd_t cmd
);
  import nnli_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_POS_CHK  = 7'b0000010,
    ST_POS_CMP  = 7'b0000100,
    ST_BND_RD   = 7'b0001000,
    ST_BND_CAPS = 7'b0010000,
    ST_BND_CAPE = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  // Take a transaction only while idle and the output slot can hold a result
  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign take      = in_tready && in_tvalid;

  // Drive commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.accept    = take;
    cmd.pos_chk   = (state_r == ST_POS_CHK);
    cmd.pos_cmp   = (state_r == ST_POS_CMP);
    cmd.bnd_rd    = (state_r == ST_BND_RD);
    cmd.bnd_caps  = (state_r == ST_BND_CAPS);
    cmd.bnd_cape  = (state_r == ST_BND_CAPE);
    cmd.done_load = (state_r == ST_DONE) && sts.out_free;
  end

  // Sequence the table lookups
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && sts.go_pos) state_nxt = ST_POS_CHK;
        else if (take && sts.go_bnd) state_nxt = ST_BND_RD;
      end
      ST_POS_CHK:  state_nxt = sts.lo_lt_hi ? ST_POS_CMP : ST_DONE;
      ST_POS_CMP:  state_nxt = ST_POS_CHK;
      ST_BND_RD:   state_nxt = ST_BND_CAPS;
      ST_BND_CAPS: state_nxt = sts.ln_lt_total ? ST_BND_CAPE : ST_DONE;
      ST_BND_CAPE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/nnli_dp.sv =====
module nnli_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          in_tuser,  // op
  input  logic [nnli_pkg::IN_DATA_W-1:0]      in_tdata,  // data_byte, position, line_number
  input  nnli_pkg::cmd_t                      cmd,
  output nnli_pkg::sts_t                      sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nnli_pkg::OUT_DATA_W-1:0]     out_tdata, // byte_out, found_line,
                                                         // start_offset, end_offset,
                                                         // total_lines, text_length
  output logic [2:0]                          out_tuser  // status, byte_emitted
);
  import nnli_pkg::*;

  // Input fields
  logic [1:0]      in_op;
  logic [7:0]      in_byte;
  logic [BC_W-1:0] in_pos;
  logic [LN_W-1:0] in_ln;

  assign in_op   = in_tuser;
  assign in_byte = in_tdata[7:0];
  assign in_pos  = in_tdata[8 +: BC_W];
  assign in_ln   = in_tdata[8 + BC_W +: LN_W];

  // Text state
  logic            cr_pending_r, cr_pending_nxt;
  logic            last_lf_r, last_lf_nxt;
  logic [BC_W-1:0] byte_count_r, byte_count_nxt;
  logic [LF_W-1:0] lf_count_r, lf_count_nxt;
  logic            finished_r, finished_nxt;
  logic            overflowed_r, overflowed_nxt;

  // Line start table
  logic [BC_W-1:0] line_tab [MAX_LINES];
  logic            wr_en;
  logic [LF_W-1:0] wr_addr;
  logic            rd_en;
  logic [LF_W-1:0] rd_addr;
  logic [BC_W-1:0] rd_data_r;

  // Query registers
  logic            q_is_pos_r;
  logic [BC_W-1:0] q_pos_r;
  logic [LN_W-1:0] q_ln_r;
  logic [LN_W-1:0] lo_r, hi_r, mid_r;
  logic [LN_W-1:0] mid;
  logic [BC_W-1:0] start_r, end_r;
  logic [BC_W-1:0] mid_start;

  // Output register
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [7:0]      out_byte_r;
  logic            out_emit_r;
  logic [LN_W-1:0] out_found_r;
  logic [BC_W-1:0] out_start_r, out_end_r;
  logic [LN_W-1:0] out_total_r;
  logic [BC_W-1:0] out_len_r;

  // Immediate result of an accepted item
  logic [1:0]      res_status;
  logic [7:0]      res_byte;
  logic            res_emit;
  logic [LN_W-1:0] res_total;
  logic [BC_W-1:0] res_len;
  logic            go_pos, go_bnd;

  logic [7:0]      norm_byte;
  logic            norm_lf;
  logic [LN_W-1:0] lf_p1;
  logic            byte_full;
  logic            line_full;
  logic            load;

  assign norm_byte = (in_byte == CH_CR) ? CH_LF : in_byte;
  assign norm_lf   = (norm_byte == CH_LF);
  assign lf_p1     = {1'b0, lf_count_r} + LN_W'(1);
  assign byte_full = (byte_count_r >= BC_W'(MAX_BYTES));
  assign line_full = (lf_p1 >= LN_W'(MAX_LINES));

  // Decode the item against the text state
  always_comb begin
    cr_pending_nxt = cr_pending_r;
    last_lf_nxt    = last_lf_r;
    byte_count_nxt = byte_count_r;
    lf_count_nxt   = lf_count_r;
    finished_nxt   = finished_r;
    overflowed_nxt = overflowed_r;
    res_status     = STAT_OK;
    res_byte       = '0;
    res_emit       = 1'b0;
    res_total      = '0;
    res_len        = '0;
    go_pos         = 1'b0;
    go_bnd         = 1'b0;
    wr_en          = 1'b0;
    unique case (in_op)
      OP_BYTE: begin
        if (finished_r) begin
          res_status = STAT_PHASE;
        end else if (overflowed_r) begin
          res_status = STAT_OVFL;
        end else if (in_byte == CH_LF && cr_pending_r) begin
          // swallow the LF of a CRLF pair
          cr_pending_nxt = 1'b0;
        end else if (byte_full || (norm_lf && line_full)) begin
          overflowed_nxt = 1'b1;
          res_status     = STAT_OVFL;
        end else begin
          byte_count_nxt = byte_count_r + BC_W'(1);
          if (norm_lf) begin
            lf_count_nxt = lf_p1[LF_W-1:0];
            wr_en        = cmd.accept;
          end
          last_lf_nxt    = norm_lf;
          cr_pending_nxt = (in_byte == CH_CR);
          res_byte       = norm_byte;
          res_emit       = 1'b1;
        end
      end
      OP_FINISH: begin
        if (finished_r) begin
          res_status = STAT_PHASE;
        end else begin
          finished_nxt   = 1'b1;
          cr_pending_nxt = 1'b0;
          if (!overflowed_r && !last_lf_r) begin
            if (!byte_full && !line_full) begin
              byte_count_nxt = byte_count_r + BC_W'(1);
              lf_count_nxt   = lf_p1[LF_W-1:0];
              wr_en          = cmd.accept;
              last_lf_nxt    = 1'b1;
              res_byte       = CH_LF;
              res_emit       = 1'b1;
            end else begin
              overflowed_nxt = 1'b1;
            end
          end
          res_status = overflowed_nxt ? STAT_OVFL : STAT_OK;
          res_total  = {1'b0, lf_count_nxt} + LN_W'(1);
          res_len    = byte_count_nxt;
        end
      end
      OP_LINE_OF_POS: begin
        if (!finished_r) res_status = STAT_PHASE;
        else if (overflowed_r) res_status = STAT_OVFL;
        else if (in_pos > byte_count_r) res_status = STAT_RANGE;
        else go_pos = 1'b1;
      end
      OP_LINE_BOUNDS: begin
        if (!finished_r) res_status = STAT_PHASE;
        else if (overflowed_r) res_status = STAT_OVFL;
        else if (in_ln == '0 || in_ln > lf_p1) res_status = STAT_RANGE;
        else go_bnd = 1'b1;
      end
      default: res_status = STAT_PHASE;
    endcase
  end

  assign wr_addr = lf_count_nxt;

  // Status towards the controller
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  always_comb begin
    sts             = '0;
    sts.go_pos      = go_pos;
    sts.go_bnd      = go_bnd;
    sts.lo_lt_hi    = (lo_r < hi_r);
    sts.ln_lt_total = (q_ln_r < lf_p1);
    sts.out_free    = !out_valid_r || out_tready;
  end

  // Select the table read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.pos_chk) begin
      rd_en   = 1'b1;
      rd_addr = mid[LF_W-1:0];
    end else if (cmd.bnd_rd) begin
      rd_en   = 1'b1;
      rd_addr = LF_W'(q_ln_r - LN_W'(1));
    end else if (cmd.bnd_caps) begin
      rd_en   = 1'b1;
      rd_addr = q_ln_r[LF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_tab[wr_addr] <= byte_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= line_tab[rd_addr];
  end

  // Line zero starts at offset zero and is not stored
  assign mid_start = (mid_r == '0) ? '0 : rd_data_r;

  // Hold the text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_pending_r <= 1'b0;
      last_lf_r    <= 1'b0;
      byte_count_r <= '0;
      lf_count_r   <= '0;
      finished_r   <= 1'b0;
      overflowed_r <= 1'b0;
    end else if (cmd.accept) begin
      cr_pending_r <= cr_pending_nxt;
      last_lf_r    <= last_lf_nxt;
      byte_count_r <= byte_count_nxt;
      lf_count_r   <= lf_count_nxt;
      finished_r   <= finished_nxt;
      overflowed_r <= overflowed_nxt;
    end
  end

  // Advance the query
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_is_pos_r <= go_pos;
      q_pos_r    <= in_pos;
      q_ln_r     <= in_ln;
      lo_r       <= '0;
      hi_r       <= lf_p1;
    end
    if (cmd.pos_chk) mid_r <= mid;
    if (cmd.pos_cmp) begin
      if (q_pos_r < mid_start) hi_r <= mid_r;
      else lo_r <= mid_r + LN_W'(1);
    end
    if (cmd.bnd_caps) begin
      start_r <= (q_ln_r == LN_W'(1)) ? '0 : rd_data_r;
      end_r   <= byte_count_r;
    end
    if (cmd.bnd_cape) end_r <= rd_data_r - BC_W'(1);
  end

  // Load the output register
  assign load = (cmd.accept && !go_pos && !go_bnd) || cmd.done_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done_load) begin
      out_status_r <= STAT_OK;
      out_byte_r   <= '0;
      out_emit_r   <= 1'b0;
      out_found_r  <= q_is_pos_r ? lo_r : '0;
      out_start_r  <= q_is_pos_r ? '0 : start_r;
      out_end_r    <= q_is_pos_r ? '0 : end_r;
      out_total_r  <= '0;
      out_len_r    <= '0;
    end else if (load) begin
      out_status_r <= res_status;
      out_byte_r   <= res_byte;
      out_emit_r   <= res_emit;
      out_found_r  <= '0;
      out_start_r  <= '0;
      out_end_r    <= '0;
      out_total_r  <= res_total;
      out_len_r    <= res_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_len_r, out_total_r, out_end_r, out_start_r,
                       out_found_r, out_byte_r};
  assign out_tuser  = {out_emit_r, out_status_r};

  // Overflow and finish are sticky until reset
  a_ovfl_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflowed_r |=> overflowed_r)
    else $error("overflow flag cleared");

  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finish flag cleared");

  // Every stored LF is also counted as a byte
  a_lf_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    BC_W'(lf_count_r) <= byte_count_r)
    else $error("LF count exceeds byte count");

  // An emitted byte always comes with an ok status
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_emit_r) |-> (out_status_r == STAT_OK))
    else $error("emitted byte with error status");

endmodule

// ===== rtl/newline_normalizer_line_index_core.sv =====
// Newline normaliser with a line-start index. Source bytes (op 0) are taken one
// per cycle while the output can take a result: CR and CRLF leave as LF, and
// each LF records the start of the next line in a 4096-entry table. Finish
// (op 1) appends an LF where needed and reports the length and line count. Every
// transaction gets exactly one result. A line-of-position query (op 2) runs a
// binary search, each step a check state and a compare state, set by the single
// table read port with its registered read data; a bounds-of-line query (op 3)
// steps through a read state and capture states for the line start and, unless
// it is the last line, its end. Errors go straight to the output register. The
// table is not cleared after reset; only entries written since reset are used.
module newline_normalizer_line_index_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nnli_pkg::IN_DATA_W-1:0]  in_tdata,   // data_byte, position, line_number
  input  logic [1:0]                      in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nnli_pkg::OUT_DATA_W-1:0] out_tdata,  // byte_out, found_line, start_offset,
                                                      // end_offset, total_lines, text_length
  output logic [2:0]                      out_tuser   // status, byte_emitted
);
  import nnli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nnli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nnli_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
